// ----- rtl/core/step_command_deframer_unit_macros.svh -----
// assertion helpers for the step command deframer
`ifndef STEP_COMMAND_DEFRAMER_UNIT_MACROS_SVH
`define STEP_COMMAND_DEFRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle
`define SCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequent must hold in the next cycle
`define SCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SCD_ASSERT_SAME(label, ante, cons)
`define SCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/scd_pkg.sv -----
package scd_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned MAG_W     = 16;

    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] CHECK_BYTE = 8'hFF;

    // input mode codes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // frame slot positions
    localparam logic [POS_W-1:0] SLOT_RESYNC = 4'd2;
    localparam logic [POS_W-1:0] SLOT_LAST   = 4'd8;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    // slot 8 first
    localparam frame_t FRAME_RESET = {8'hFA, 8'hFF, 8'h02, 8'h00, 8'h00,
                                      8'h00, 8'h00, 8'h00, 8'h00};

    typedef logic signed [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } load_t;

    typedef struct packed {
        logic step_lr;
        logic dir_lr;
        logic step_ud;
        logic dir_ud;
    } step_t;

endpackage

// ----- rtl/core/scd_if.sv -----
interface scd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface scd_out_if;
    logic                     valid;
    logic                     ready;
    logic                     frame_loaded;
    logic                     step_lr;
    logic                     dir_lr;
    logic                     step_ud;
    logic                     dir_ud;
    logic signed [16:0]       steps_left;

    modport source (output valid, output frame_loaded, output step_lr, output dir_lr,
                    output step_ud, output dir_ud, output steps_left, input ready);
    modport sink (input valid, input frame_loaded, input step_lr, input dir_lr,
                  input step_ud, input dir_ud, input steps_left, output ready);
endinterface

// ----- rtl/core/step_command_deframer_unit.sv -----
// step command deframer
// cmd channel: one transfer is either a received serial byte (mode 0, data_byte)
// or a timer tick (mode 1). bytes build a 9-byte frame; a doubled 0xAA resyncs
// the frame and a doubled 0xFF checks it. a valid frame loads both signed step
// counts, reported by frame_loaded.
// result channel: exactly one transfer per cmd transfer, in order. on a tick,
// step_lr/step_ud pulse for each motor whose count is nonzero, dir_* gives the
// sign, and the count moves one toward zero. steps_left is the left-right count
// after the item.
// latency: the result is valid the cycle after the cmd transfer.
// throughput: one item per cycle unless result stalls; the frame and counter
// update is a single combinational pass into the state and result registers.
// stall: the result register holds while result.ready is low; cmd.ready stays
// high as long as the held result is taken in the same cycle.
// reset: frame store, write position, previous byte and counts return to their
// initial values and no result is pending.
`include "step_command_deframer_unit_macros.svh"

module step_command_deframer_unit
(
    input  logic      clk,
    input  logic      rst_n,
    scd_in_if.sink    cmd,
    scd_out_if.source result
);

    logic            accept;
    logic            byte_valid;
    logic            tick;
    scd_pkg::load_t  load;
    scd_pkg::step_t  steps;
    scd_pkg::count_t count_lr;

    logic            valid_reg;
    logic            loaded_reg;
    scd_pkg::step_t  steps_reg;
    scd_pkg::count_t count_reg;

    assign cmd.ready  = !valid_reg || result.ready;
    assign accept     = cmd.valid && cmd.ready;
    assign byte_valid = accept && (cmd.mode == scd_pkg::MODE_BYTE);
    assign tick       = accept && (cmd.mode == scd_pkg::MODE_TICK);

    scd_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (cmd.data_byte),
        .load       (load)
    );

    scd_motor u_motor
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .load     (load),
        .steps    (steps),
        .count_lr (count_lr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            loaded_reg <= load.valid;
            steps_reg  <= steps;
            count_reg  <= count_lr;
        end
    end

    assign result.valid        = valid_reg;
    assign result.frame_loaded = loaded_reg;
    assign result.step_lr      = steps_reg.step_lr;
    assign result.dir_lr       = steps_reg.dir_lr;
    assign result.step_ud      = steps_reg.step_ud;
    assign result.dir_ud       = steps_reg.dir_ud;
    assign result.steps_left   = count_reg;

    `SCD_ASSERT_SAME(a_load_has_no_step, result.valid && result.frame_loaded,
                     !result.step_lr && !result.step_ud)
    `SCD_ASSERT_NEXT(a_accept_gives_result, accept, result.valid)

endmodule

// ----- rtl/core/scd_frame.sv -----
`include "step_command_deframer_unit_macros.svh"

module scd_frame
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic [7:0]     data_byte,
    output scd_pkg::load_t load
);

    scd_pkg::frame_t                 frame_reg;
    scd_pkg::frame_t                 frame_next;
    logic [scd_pkg::POS_W-1:0]       pos_reg;
    logic [scd_pkg::POS_W-1:0]       pos_next;
    logic [7:0]                      prev_reg;
    logic [7:0]                      prev_next;
    logic                            sync_pair;
    logic                            check_pair;
    logic [9:0]                      slot_sum;
    logic                            frame_ok;

    assign sync_pair  = (data_byte == prev_reg) && (data_byte == scd_pkg::SYNC_BYTE);
    assign check_pair = (data_byte == prev_reg) && (data_byte == scd_pkg::CHECK_BYTE);

    // full-width sum of motor id, direction and both count bytes
    assign slot_sum = {2'b00, frame_reg[2]} + {2'b00, frame_reg[3]}
                    + {2'b00, frame_reg[4]} + {2'b00, frame_reg[5]};

    assign frame_ok = (slot_sum == {2'b00, frame_reg[6]}) && (frame_reg[2] == 8'h00)
                    && (frame_reg[3][7:1] == 7'd0);

    always_comb
    begin
        frame_next = frame_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        load.valid = 1'b0;
        load.neg   = frame_reg[3][0];
        load.mag   = {frame_reg[4], frame_reg[5]};
        if (byte_valid)
        begin
            prev_next = data_byte;
            if (sync_pair)
            begin
                pos_next      = scd_pkg::SLOT_RESYNC;
                frame_next[0] = scd_pkg::SYNC_BYTE;
                frame_next[1] = scd_pkg::SYNC_BYTE;
            end
            else if (check_pair)
            begin
                load.valid = frame_ok;
            end
            else
            begin
                frame_next[pos_reg] = data_byte;
                pos_next = (pos_reg == scd_pkg::SLOT_LAST) ? '0 : pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= scd_pkg::FRAME_RESET;
            pos_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
        end
    end

    `SCD_ASSERT_SAME(a_pos_in_range, 1'b1, pos_reg <= scd_pkg::SLOT_LAST)
    `SCD_ASSERT_NEXT(a_resync, byte_valid && sync_pair,
                     pos_reg == scd_pkg::SLOT_RESYNC && frame_reg[1] == scd_pkg::SYNC_BYTE)

endmodule

// ----- rtl/core/scd_motor.sv -----
`include "step_command_deframer_unit_macros.svh"

module scd_motor
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  scd_pkg::load_t  load,
    output scd_pkg::step_t  steps,
    output scd_pkg::count_t count_lr
);

    scd_pkg::count_t count_lr_reg;
    scd_pkg::count_t count_lr_next;
    scd_pkg::count_t count_ud_reg;
    scd_pkg::count_t count_ud_next;
    scd_pkg::count_t load_value;

    assign load_value = load.neg ? -$signed({1'b0, load.mag}) : $signed({1'b0, load.mag});

    always_comb
    begin
        count_lr_next = count_lr_reg;
        count_ud_next = count_ud_reg;
        steps         = '0;
        if (load.valid)
        begin
            count_lr_next = load_value;
            count_ud_next = load_value;
        end
        else if (tick)
        begin
            // each nonzero count moves one step toward zero
            if (count_lr_reg != '0)
            begin
                steps.step_lr = 1'b1;
                steps.dir_lr  = count_lr_reg[scd_pkg::COUNT_W-1];
                count_lr_next = count_lr_reg[scd_pkg::COUNT_W-1] ? count_lr_reg + 17'sd1
                                                                   : count_lr_reg - 17'sd1;
            end
            if (count_ud_reg != '0)
            begin
                steps.step_ud = 1'b1;
                steps.dir_ud  = count_ud_reg[scd_pkg::COUNT_W-1];
                count_ud_next = count_ud_reg[scd_pkg::COUNT_W-1] ? count_ud_reg + 17'sd1
                                                                   : count_ud_reg - 17'sd1;
            end
        end
    end

    assign count_lr = count_lr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_lr_reg <= '0;
            count_ud_reg <= '0;
        end
        else
        begin
            count_lr_reg <= count_lr_next;
            count_ud_reg <= count_ud_next;
        end
    end

    `SCD_ASSERT_NEXT(a_idle_lr_stays, tick && !load.valid && count_lr_reg == '0,
                     count_lr_reg == '0)
    `SCD_ASSERT_SAME(a_no_load_on_tick, tick, !load.valid)

endmodule

// ----- verif/tb_step_command_deframer_unit.sv -----
module tb_step_command_deframer_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1225;
    localparam int HOLD_START  = 300;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } cmd_item_t;

    typedef struct packed {
        logic            frame_loaded;
        logic            step_lr;
        logic            dir_lr;
        logic            step_ud;
        logic            dir_ud;
        scd_pkg::count_t steps_left;
    } motor_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scd_in_if  cmd_if ();
    scd_out_if res_if ();

    step_command_deframer_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if)
    );

    always #10 clk = ~clk;

    // predicted deframer state
    scd_pkg::frame_t frame_bytes;
    logic [3:0]      wr_pos;
    logic [7:0]      last_rx_byte;
    scd_pkg::count_t lr_count;
    scd_pkg::count_t ud_count;

    cmd_item_t     cmd_queue [$];
    motor_report_t pending_reports [$];

    cmd_item_t     next_cmd;
    motor_report_t want_rep;

    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  items_accepted = 0;
    int  tx_wait        = 0;
    int  rx_wait        = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  tx_quiet       = 1'b0;
    bit  rx_quiet       = 1'b0;
    bit  cmd_fire       = 1'b0;
    bit  res_fire       = 1'b0;

    function automatic void advance_motor(inout scd_pkg::count_t cnt, output logic stp,
                                          output logic dir);
        stp = 1'b0;
        dir = 1'b0;
        if (cnt > 0)
        begin
            stp = 1'b1;
            cnt = cnt - 1;
        end
        else if (cnt < 0)
        begin
            stp = 1'b1;
            dir = 1'b1;
            cnt = cnt + 1;
        end
    endfunction

    function automatic motor_report_t deframe_item(logic mode, logic [7:0] b);
        motor_report_t rep;
        int            sum;
        logic [15:0]   mag;
        rep = '0;
        if (mode == scd_pkg::MODE_TICK)
        begin
            advance_motor(lr_count, rep.step_lr, rep.dir_lr);
            advance_motor(ud_count, rep.step_ud, rep.dir_ud);
        end
        else
        begin
            if (b == last_rx_byte && b == scd_pkg::SYNC_BYTE)
            begin
                wr_pos = scd_pkg::SLOT_RESYNC;
                frame_bytes[0] = scd_pkg::SYNC_BYTE;
                frame_bytes[1] = scd_pkg::SYNC_BYTE;
            end
            else if (b == last_rx_byte && b == scd_pkg::CHECK_BYTE)
            begin
                // full-width sum, no 8-bit wrap
                sum = frame_bytes[2] + frame_bytes[3] + frame_bytes[4] + frame_bytes[5];
                if (sum == frame_bytes[6] && frame_bytes[2] == 8'h00 && frame_bytes[3] <= 8'h01)
                begin
                    mag = {frame_bytes[4], frame_bytes[5]};
                    lr_count = (frame_bytes[3] == 8'h00) ? scd_pkg::count_t'({1'b0, mag})
                                                         : -scd_pkg::count_t'({1'b0, mag});
                    ud_count = lr_count;
                    rep.frame_loaded = 1'b1;
                end
            end
            else
            begin
                if (wr_pos >= scd_pkg::FRAME_LEN)
                    wr_pos = '0;
                frame_bytes[wr_pos] = b;
                wr_pos = (wr_pos == scd_pkg::SLOT_LAST) ? 4'd0 : wr_pos + 4'd1;
            end
            last_rx_byte = b;
        end
        rep.steps_left = lr_count;
        return rep;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic push_byte(logic [7:0] b);
        cmd_queue.push_back('{mode: scd_pkg::MODE_BYTE, data_byte: b});
    endtask

    task automatic push_tick();
        cmd_queue.push_back('{mode: scd_pkg::MODE_TICK, data_byte: 8'($urandom)});
    endtask

    // sync pair, motor id, direction, count high/low, checksum, check pair
    task automatic push_frame(logic [7:0] id, logic [7:0] dir, logic [7:0] hi,
                              logic [7:0] lo, logic [7:0] sum_err);
        logic [7:0] sum;
        sum = id + dir + hi + lo + sum_err;
        push_byte(scd_pkg::SYNC_BYTE);
        push_byte(scd_pkg::SYNC_BYTE);
        push_byte(id);
        push_byte(dir);
        push_byte(hi);
        push_byte(lo);
        push_byte(sum);
        push_byte(scd_pkg::CHECK_BYTE);
        push_byte(scd_pkg::CHECK_BYTE);
    endtask

    // acceptance, prediction and result checking
    always @(posedge clk)
    begin
        cmd_fire = rst_n && cmd_if.valid && cmd_if.ready;
        res_fire = rst_n && res_if.valid && res_if.ready;
        if (rst_n)
            cycle_count++;
        if (res_fire)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want_rep = pending_reports.pop_front();
                check_field("frame_loaded", want_rep.frame_loaded, res_if.frame_loaded);
                check_field("step_lr", want_rep.step_lr, res_if.step_lr);
                check_field("dir_lr", want_rep.dir_lr, res_if.dir_lr);
                check_field("step_ud", want_rep.step_ud, res_if.step_ud);
                check_field("dir_ud", want_rep.dir_ud, res_if.dir_ud);
                check_field("steps_left", want_rep.steps_left, res_if.steps_left);
            end
        end
        if (cmd_fire)
        begin
            pending_reports.push_back(deframe_item(cmd_if.mode, cmd_if.data_byte));
            items_accepted++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // command driver
    always @(negedge clk)
    begin
        if (rst_n && !(cmd_if.valid && !cmd_fire))
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                cmd_if.valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                next_cmd = cmd_queue.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.mode      <= next_cmd.mode;
                cmd_if.data_byte <= next_cmd.data_byte;
                if ($urandom_range(0, 39) == 0)
                    tx_quiet = !tx_quiet;
                tx_wait = (tx_quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 15);
            end
            else
            begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the block backs up into the command side
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && items_accepted >= HOLD_START)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                rx_wait = (rx_quiet || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 15);
            end
            if (hold_left > 0)
                res_if.ready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int         n_items;
        int         kind;
        logic [7:0] id;
        logic [7:0] dir;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] sum_err;

        cmd_if.valid     = 1'b0;
        cmd_if.mode      = scd_pkg::MODE_BYTE;
        cmd_if.data_byte = 8'h00;
        res_if.ready     = 1'b0;

        frame_bytes  = scd_pkg::FRAME_RESET;
        wr_pos       = '0;
        last_rx_byte = 8'h00;
        lr_count     = '0;
        ud_count     = '0;

        // idle tick, check pair on the power-up frame (rejected)
        cmd_queue.push_back('{mode: scd_pkg::MODE_TICK, data_byte: 8'hFF});
        push_byte(scd_pkg::CHECK_BYTE);
        push_byte(scd_pkg::CHECK_BYTE);
        // largest count; checksum 0xFF runs straight into a repeated check
        push_frame(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
        push_tick();
        // reverse direction, counted up to zero and held there
        push_frame(8'h00, 8'h01, 8'h00, 8'h02, 8'h00);
        repeat (3) push_tick();

        while (cmd_queue.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                id  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                dir = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
                                                  : 8'($urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0)
                begin
                    hi = 8'($urandom_range(0, 255));
                    lo = 8'($urandom_range(0, 255 - hi));
                end
                else
                begin
                    hi = 8'h00;
                    lo = 8'($urandom_range(0, 20));
                end
                sum_err = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                push_frame(id, dir, hi, lo, sum_err);
                repeat ($urandom_range(0, 25)) push_tick();
            end
            else if (kind <= 7)
            begin
                repeat ($urandom_range(1, 12))
                begin
                    case ($urandom_range(0, 5))
                        0:       push_byte(scd_pkg::SYNC_BYTE);
                        1:       push_byte(scd_pkg::CHECK_BYTE);
                        default: push_byte(8'($urandom));
                    endcase
                end
            end
            else if (kind == 8)
            begin
                // truncated frame after a resync
                push_byte(scd_pkg::SYNC_BYTE);
                push_byte(scd_pkg::SYNC_BYTE);
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
                if ($urandom_range(0, 1))
                begin
                    push_byte(scd_pkg::CHECK_BYTE);
                    push_byte(scd_pkg::CHECK_BYTE);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10)) push_tick();
            end
        end
        n_items = cmd_queue.size();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        while (!(items_accepted == n_items && pending_reports.size() == 0))
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
